>>> design/rx_packet_slot_manager_macros.svh
// assertion macros for the rx packet slot manager
// expects signals named clock and reset in the including module
`ifndef RX_PACKET_SLOT_MANAGER_MACROS_SVH
`define RX_PACKET_SLOT_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
`define RXPSM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rxpsm: check failed");
`define RXPSM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rxpsm: check failed");
`else
`define RXPSM_ASSERT(label, prop)
`define RXPSM_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> design/rxpsm_pkg.sv
// shared types, constants and position helpers of the rx packet slot manager
// no dependencies
`default_nettype none
package rxpsm_pkg;

   localparam int SLOT_COUNT   = 16;
   localparam int NODE_ID_BITS = 8;
   localparam int SLOT_BITS    = $clog2(SLOT_COUNT);
   localparam int COUNT_BITS   = SLOT_BITS + 1;
   localparam int MODE_BITS    = 3;

   localparam int REQ_FIELD_BITS = SLOT_BITS + NODE_ID_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 1 + 3 * SLOT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(2);
   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(SLOT_COUNT);

   localparam logic [MODE_BITS-1:0] MODE_ALLOC   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_ENQUEUE = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_FLUSH   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_PEEK    = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_POP     = 3'd4;

   typedef enum logic [1:0] {
      SWEEP_ALLOC,
      SWEEP_FLUSH,
      SWEEP_SKIP
   } sweep_op_type;

   // what travels from cell to cell along the chain
   typedef struct packed {
      logic                  token;
      sweep_op_type          op;
      logic                  found;
      logic [SLOT_BITS-1:0]  head_gap;
      logic [SLOT_BITS-1:0]  pos;
      logic [SLOT_BITS-1:0]  slot;
      logic [SLOT_COUNT-1:0] free_mask;
   } carry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                    clear_all;
      logic                    ent_we;
      logic [SLOT_BITS-1:0]    ent_pos;
      logic [SLOT_BITS-1:0]    ent_slot;
      logic                    src_we;
      logic [SLOT_BITS-1:0]    src_slot;
      logic [NODE_ID_BITS-1:0] node;
      logic [SLOT_COUNT-1:0]   busy_clr;
      logic                    kill_we;
      logic [SLOT_BITS-1:0]    kill_pos;
      logic [SLOT_BITS-1:0]    head;
      logic [SLOT_BITS-1:0]    level;
      logic [COUNT_BITS-1:0]   count;
   } cmd_type;

   function automatic logic [SLOT_BITS-1:0] next_pos(input logic [SLOT_BITS-1:0] p,
                                                    input logic [COUNT_BITS-1:0] count);
      logic [COUNT_BITS-1:0] inc;
      inc = {1'b0, p} + COUNT_BITS'(1);
      if (inc >= count) begin
         return '0;
      end
      return inc[SLOT_BITS-1:0];
   endfunction

   // circular distance from b forward to a
   function automatic logic [SLOT_BITS-1:0] circ_dist(input logic [SLOT_BITS-1:0] a,
                                                     input logic [SLOT_BITS-1:0] b,
                                                     input logic [COUNT_BITS-1:0] count);
      logic [COUNT_BITS-1:0] diff;
      if (a >= b) begin
         diff = {1'b0, a} - {1'b0, b};
      end else begin
         diff = {1'b0, a} + count - {1'b0, b};
      end
      return diff[SLOT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

>>> design/rxpsm_cell.sv
// one cell of the chain: a queue position and a slot with its busy flag and source
// depends on rxpsm_pkg
`default_nettype none
module rxpsm_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rxpsm_pkg::SLOT_BITS-1:0]       cell_idx,
   input  rxpsm_pkg::cmd_type                    cmd,
   input  logic [rxpsm_pkg::SLOT_COUNT-1:0]      match_vec,
   input  rxpsm_pkg::carry_type                  chain_in,
   output rxpsm_pkg::carry_type                  chain_out,
   output logic                                  match
);
   import rxpsm_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    valid_ff, valid_in;
   logic [SLOT_BITS-1:0]    slot_ff, slot_in;
   logic [NODE_ID_BITS-1:0] source_ff, source_in;
   carry_type               carry_ff, carry_in;
   logic                    in_use;
   logic                    in_range;
   logic [SLOT_BITS-1:0]    head_gap;

   always_comb begin
      in_use    = {1'b0, cell_idx} < cmd.count;
      head_gap  = circ_dist(cell_idx, cmd.head, cmd.count);
      in_range  = in_use && (head_gap < cmd.level);
      busy_in   = busy_ff;
      valid_in  = valid_ff;
      slot_in   = slot_ff;
      source_in = source_ff;
      carry_in  = chain_in;

      if (chain_in.token) begin
         case (chain_in.op)
            SWEEP_ALLOC: begin
               if (!chain_in.found && in_use && !busy_ff) begin
                  busy_in        = 1'b1;
                  carry_in.found = 1'b1;
                  carry_in.pos   = cell_idx;
               end
            end
            SWEEP_FLUSH: begin
               if (in_range && valid_ff && match_vec[slot_ff]) begin
                  valid_in                    = 1'b0;
                  carry_in.free_mask[slot_ff] = 1'b1;
               end
            end
            SWEEP_SKIP: begin
               // nearest valid entry at or after the head, in circular order
               if (in_range && valid_ff &&
                   (!chain_in.found || head_gap < chain_in.head_gap)) begin
                  carry_in.found    = 1'b1;
                  carry_in.head_gap = head_gap;
                  carry_in.pos      = cell_idx;
                  carry_in.slot     = slot_ff;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.ent_we && cmd.ent_pos == cell_idx) begin
         valid_in = 1'b1;
         slot_in  = cmd.ent_slot;
      end
      if (cmd.src_we && cmd.src_slot == cell_idx) begin
         source_in = cmd.node;
      end
      if (cmd.busy_clr[cell_idx]) begin
         busy_in = 1'b0;
      end
      if (cmd.kill_we && cmd.kill_pos == cell_idx) begin
         valid_in = 1'b0;
      end
      if (cmd.clear_all) begin
         busy_in  = 1'b0;
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         carry_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      source_ff <= source_in;
   end

   assign chain_out = carry_ff;
   assign match     = (source_ff == cmd.node);

endmodule
`default_nettype wire

>>> design/rxpsm_ctrl.sv
// controller: head and tail pointers, level mark, sweep launch and result register
// depends on rxpsm_pkg
`default_nettype none
module rxpsm_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rxpsm_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [rxpsm_pkg::SLOT_BITS-1:0]       req_slot,
   input  logic [rxpsm_pkg::NODE_ID_BITS-1:0]    req_src_node,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic                                  rsp_status,
   output logic [rxpsm_pkg::SLOT_BITS-1:0]       rsp_result_slot,
   output logic [rxpsm_pkg::SLOT_BITS-1:0]       rsp_queue_level,
   output logic [rxpsm_pkg::SLOT_BITS-1:0]       rsp_high_water,
   input  logic                                  csr_we,
   input  logic [rxpsm_pkg::COUNT_BITS-1:0]      csr_wdata,
   output rxpsm_pkg::cmd_type                    cmd,
   output rxpsm_pkg::carry_type                  inject,
   input  rxpsm_pkg::carry_type                  chain_tail
);
   import rxpsm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_REPORT
   } state_type;

   state_type               state_ff, state_in;
   logic [SLOT_BITS-1:0]    head_ff, head_in;
   logic [SLOT_BITS-1:0]    tail_ff, tail_in;
   logic [SLOT_BITS-1:0]    peak_ff, peak_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [MODE_BITS-1:0]    mode_ff, mode_in;
   logic [NODE_ID_BITS-1:0] node_ff, node_in;
   logic                    status_ff, status_in;
   logic [SLOT_BITS-1:0]    result_ff, result_in;
   carry_type               inject_ff, inject_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [SLOT_BITS-1:0]    rsp_level_ff, rsp_level_in;
   logic [SLOT_BITS-1:0]    rsp_peak_ff, rsp_peak_in;

   logic [SLOT_BITS-1:0]    level;
   logic [SLOT_BITS-1:0]    tail_next;
   logic                    full;
   logic                    ready;
   logic                    accept;

   always_comb begin
      level     = circ_dist(tail_ff, head_ff, count_ff);
      tail_next = next_pos(tail_ff, count_ff);
      full      = (tail_next == head_ff);
      ready     = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
      accept    = req_tvalid && ready;

      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      peak_in       = peak_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      node_in       = node_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      inject_in     = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_peak_in   = rsp_peak_ff;

      cmd       = '0;
      cmd.node  = node_ff;
      cmd.head  = head_ff;
      cmd.level = level;
      cmd.count = count_ff;

      if (csr_we) begin
         if (csr_wdata < MIN_COUNT) begin
            count_in = MIN_COUNT;
         end else if (csr_wdata > MAX_COUNT) begin
            count_in = MAX_COUNT;
         end else begin
            count_in = csr_wdata;
         end
         head_in       = '0;
         tail_in       = '0;
         cmd.clear_all = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = req_mode;
               node_in   = req_src_node;
               status_in = 1'b0;
               result_in = '0;
               state_in  = ST_REPORT;
               case (req_mode) inside
                  MODE_ALLOC: begin
                     if (full) begin
                        status_in = 1'b1;
                     end else begin
                        inject_in.token = 1'b1;
                        inject_in.op    = SWEEP_ALLOC;
                        state_in        = ST_SWEEP;
                     end
                  end
                  MODE_ENQUEUE: begin
                     if (full) begin
                        status_in = 1'b1;
                     end else begin
                        cmd.ent_we   = 1'b1;
                        cmd.ent_pos  = tail_ff;
                        cmd.ent_slot = req_slot;
                        cmd.src_we   = 1'b1;
                        cmd.src_slot = req_slot;
                        cmd.node     = req_src_node;
                        tail_in      = tail_next;
                     end
                  end
                  MODE_FLUSH: begin
                     inject_in.token = 1'b1;
                     inject_in.op    = SWEEP_FLUSH;
                     state_in        = ST_SWEEP;
                  end
                  MODE_PEEK, MODE_POP: begin
                     inject_in.token = 1'b1;
                     inject_in.op    = SWEEP_SKIP;
                     state_in        = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // finish once the token leaves the last cell
            if (chain_tail.token) begin
               state_in = ST_REPORT;
               case (mode_ff) inside
                  MODE_ALLOC: begin
                     status_in = !chain_tail.found;
                     result_in = chain_tail.found ? chain_tail.pos : '0;
                  end
                  MODE_FLUSH: begin
                     cmd.busy_clr = chain_tail.free_mask;
                  end
                  MODE_PEEK, MODE_POP: begin
                     if (!chain_tail.found) begin
                        status_in = 1'b1;
                        head_in   = tail_ff;
                     end else begin
                        result_in = chain_tail.slot;
                        if (mode_ff == MODE_POP) begin
                           cmd.busy_clr[chain_tail.slot] = 1'b1;
                           cmd.kill_we                   = 1'b1;
                           cmd.kill_pos                  = chain_tail.pos;
                           head_in = next_pos(chain_tail.pos, count_ff);
                        end else begin
                           head_in = chain_tail.pos;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REPORT: begin
            // level never exceeds the mark except just after an enqueue
            peak_in       = (level > peak_ff) ? level : peak_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_slot_in   = result_ff;
            rsp_level_in  = level;
            rsp_peak_in   = (level > peak_ff) ? level : peak_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         peak_ff       <= '0;
         count_ff      <= MAX_COUNT;
         mode_ff       <= '0;
         node_ff       <= '0;
         status_ff     <= 1'b0;
         result_ff     <= '0;
         inject_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= 1'b0;
         rsp_slot_ff   <= '0;
         rsp_level_ff  <= '0;
         rsp_peak_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         peak_ff       <= peak_in;
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         node_ff       <= node_in;
         status_ff     <= status_in;
         result_ff     <= result_in;
         inject_ff     <= inject_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_peak_ff   <= rsp_peak_in;
      end
   end

   assign req_tready      = ready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_queue_level = rsp_level_ff;
   assign rsp_high_water  = rsp_peak_ff;
   assign inject          = inject_ff;

endmodule
`default_nettype wire

>>> design/rx_packet_slot_manager.sv
// top level of the rx packet slot manager: controller plus a chain of cells
// depends on rxpsm_pkg, rxpsm_ctrl, rxpsm_cell and rx_packet_slot_manager_macros.svh
//
// Slot pool with a circular arrival queue, one item at a time. Enqueue and the
// unused modes go straight to the report state and raise rsp_tvalid from there.
// Allocate (queue not full), flush, peek and pop send a token down a chain of
// 16 cells, one cell a cycle, and raise rsp_tvalid after the token has left the
// last cell; the length of that chain sets the rate. An allocate on a full
// queue behaves like an enqueue in time. A result that waits for rsp_tready
// holds off the next item. A write to the entries-in-use register empties the
// pool and the queue and keeps the high-water mark; it must only be made while
// the block is idle.
`default_nettype none
`include "rx_packet_slot_manager_macros.svh"
module rx_packet_slot_manager (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // slot, src_node
   input  logic [rxpsm_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // mode
   input  logic [rxpsm_pkg::MODE_BITS-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // status, result_slot, queue_level, high_water
   output logic [rxpsm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                  csr_we,
   input  logic [rxpsm_pkg::COUNT_BITS-1:0]      csr_wdata
);
   import rxpsm_pkg::*;

   cmd_type                 cmd;
   carry_type               chain [SLOT_COUNT+1];
   logic [SLOT_COUNT-1:0]   match_vec;
   logic [SLOT_COUNT-1:0]   token_vec;
   logic                    rsp_status;
   logic [SLOT_BITS-1:0]    rsp_result_slot;
   logic [SLOT_BITS-1:0]    rsp_queue_level;
   logic [SLOT_BITS-1:0]    rsp_high_water;

   rxpsm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_mode        (req_tuser),
      .req_slot        (req_tdata[SLOT_BITS-1:0]),
      .req_src_node    (req_tdata[SLOT_BITS +: NODE_ID_BITS]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_result_slot (rsp_result_slot),
      .rsp_queue_level (rsp_queue_level),
      .rsp_high_water  (rsp_high_water),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .inject          (chain[0]),
      .chain_tail      (chain[SLOT_COUNT])
   );

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      rxpsm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (SLOT_BITS'(g)),
         .cmd       (cmd),
         .match_vec (match_vec),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .match     (match_vec[g])
      );
      assign token_vec[g] = chain[g+1].token;
   end

   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, rsp_high_water, rsp_queue_level,
                       rsp_result_slot, rsp_status};

   `RXPSM_ASSERT(a_single_token, $onehot0(token_vec))
   `RXPSM_ASSERT(a_busy_while_sweeping, (|token_vec) |-> !req_tready)
   `RXPSM_ASSERT(a_room_for_result, (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
   `RXPSM_ASSERT_NEXT(a_one_item_at_a_time, req_tvalid && req_tready, !req_tready)

endmodule
`default_nettype wire
